FILE: hw/rtl/dcmvf_pkg.sv
// ---------------------------------------------------------------------------
// dcmvf_pkg: shared types and helpers for the DC motor voltage feedforward
// Holds the register index codes, the register bundle and the Q16.16
// saturation helper that the core and its submodules use.
// ---------------------------------------------------------------------------
package dcmvf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int POLE_W     = 17;
  localparam int Q_W        = 32;
  localparam int PROD_W     = 2 * Q_W;
  localparam int SAT_W      = PROD_W + 2;
  localparam int FRAC_W     = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INV_TORQUE_CONSTANT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDING_RESISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDING_INDUCTANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_TO_PWM         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_POLE         = 3'd6;

  localparam logic [CFG_DATA_W-1:0] INV_TORQUE_CONSTANT_RST = 31'd65536;
  localparam logic [CFG_DATA_W-1:0] VOLT_TO_PWM_RST         = 31'd65536;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]    inv_torque_constant;
    logic [CFG_DATA_W-1:0]    back_emf_gain;
    logic [CFG_DATA_W-1:0]    winding_resistance;
    logic [CFG_DATA_W-1:0]    winding_inductance;
    logic [CFG_DATA_W-1:0]    volt_to_pwm;
    logic [CFG_DATA_W-1:0]    filter_gain;
    logic signed [POLE_W-1:0] filter_pole;
  } cfg_t;

  // Register values after reset: unity torque and PWM gains, all else zero.
  localparam cfg_t CFG_RST = '{
    inv_torque_constant: INV_TORQUE_CONSTANT_RST,
    back_emf_gain:       '0,
    winding_resistance:  '0,
    winding_inductance:  '0,
    volt_to_pwm:         VOLT_TO_PWM_RST,
    filter_gain:         '0,
    filter_pole:         '0
  };

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(33'sh0_7FFF_FFFF);
    lo = SAT_W'(32'sh8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[Q_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/dcmvf_cfg.sv
// ---------------------------------------------------------------------------
// dcmvf_cfg: configuration register file
// Seven write-only gain and filter registers loaded through a plain write port.
// ---------------------------------------------------------------------------
module dcmvf_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dcmvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcmvf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output dcmvf_pkg::cfg_t                      regs
);

  dcmvf_pkg::cfg_t regs_r;
  dcmvf_pkg::cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dcmvf_pkg::REG_INV_TORQUE_CONSTANT: regs_nxt.inv_torque_constant = cfg_wdata;
        dcmvf_pkg::REG_BACK_EMF_GAIN:       regs_nxt.back_emf_gain       = cfg_wdata;
        dcmvf_pkg::REG_WINDING_RESISTANCE:  regs_nxt.winding_resistance  = cfg_wdata;
        dcmvf_pkg::REG_WINDING_INDUCTANCE:  regs_nxt.winding_inductance  = cfg_wdata;
        dcmvf_pkg::REG_VOLT_TO_PWM:         regs_nxt.volt_to_pwm         = cfg_wdata;
        dcmvf_pkg::REG_FILTER_GAIN:         regs_nxt.filter_gain         = cfg_wdata;
        dcmvf_pkg::REG_FILTER_POLE:
          regs_nxt.filter_pole = cfg_wdata[dcmvf_pkg::POLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= dcmvf_pkg::CFG_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

FILE: hw/rtl/dcmvf_mul.sv
// ---------------------------------------------------------------------------
// dcmvf_mul: shared signed multiplier
// One 32 by 32 signed product per cycle while en is high, registered at the output.
// ---------------------------------------------------------------------------
module dcmvf_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [dcmvf_pkg::Q_W-1:0]     a,
  input  logic signed [dcmvf_pkg::Q_W-1:0]     b,
  output logic signed [dcmvf_pkg::PROD_W-1:0]  p
);

  logic signed [dcmvf_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= dcmvf_pkg::PROD_W'(a) * dcmvf_pkg::PROD_W'(b);
    end
  end

  assign p = p_r;

endmodule

FILE: hw/rtl/dc_motor_voltage_feedforward_core.sv
// ---------------------------------------------------------------------------
// dc_motor_voltage_feedforward_core: per-joint DC motor voltage feedforward
// Each accepted item is worked through by the sequencer before the next one
// is taken. The single shared multiplier forms the products in turn, nine
// per item, or five when timing_ok is low.
// Reset (synchronous, rst_n low) clears the filter history, the sequencer and
// out_valid, and restores the register reset values.
// ---------------------------------------------------------------------------
//
// The core sums the torque demands, scales the sum into a current and runs a
// first-order filtered derivative on the current and on the position. The
// drive command is then built from the back-EMF, resistive and inductive
// terms, scaled by the PWM gain. Every Q16.16 product passes through one
// registered multiplier; a small sequencer picks its operands each cycle and
// the product is consumed in the following state. Products are scaled by an
// arithmetic shift, which rounds toward minus infinity, and every stored
// result is saturated to 32 bits.
//
// The input side is ready only while the sequencer is idle. The result sits
// in an output register, so a new item may be accepted while the previous
// result still waits; the sequencer stalls in its last state if that
// register is still full.
module dc_motor_voltage_feedforward_core #(
  parameter int TORQUE_INPUTS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   in_torque_a,
  input  logic signed [31:0]                   in_torque_b,
  input  logic signed [31:0]                   in_torque_c,
  input  logic signed [31:0]                   in_shaft_pos,
  input  logic                                 in_timing_ok,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [31:0]                   out_pwm_command,
  // Configuration port.
  input  logic                                 cfg_we,
  input  logic [dcmvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcmvf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int QW  = dcmvf_pkg::Q_W;
  localparam int PW  = dcmvf_pkg::PROD_W;
  localparam int SW  = dcmvf_pkg::SAT_W;
  localparam int FW  = dcmvf_pkg::FRAC_W;
  localparam int TSW = QW + 2;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_MCUR = 4'd2;
  localparam logic [3:0] ST_CUR  = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_DM1  = 4'd5;
  localparam logic [3:0] ST_DM2  = 4'd6;
  localparam logic [3:0] ST_DY   = 4'd7;
  localparam logic [3:0] ST_VE   = 4'd8;
  localparam logic [3:0] ST_VR   = 4'd9;
  localparam logic [3:0] ST_VL   = 4'd10;
  localparam logic [3:0] ST_VSUM = 4'd11;
  localparam logic [3:0] ST_MPWM = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  dcmvf_pkg::cfg_t regs;

  dcmvf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // Control state.
  logic [3:0]              state_r, state_nxt;
  logic                    pos_phase_r, pos_phase_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Filter history, cleared by reset.
  logic signed [QW-1:0]    last_current_r, last_current_nxt;
  logic signed [QW-1:0]    last_rate_r, last_rate_nxt;
  logic signed [QW-1:0]    last_position_r, last_position_nxt;
  logic signed [QW-1:0]    last_velocity_r, last_velocity_nxt;

  // Working registers of the current item.
  logic signed [QW-1:0]    torque_in [3];
  logic signed [QW-1:0]    torque_r [TORQUE_INPUTS];
  logic signed [QW-1:0]    position_r;
  logic                    timing_ok_r;
  logic signed [QW-1:0]    sum_r, sum_nxt;
  logic signed [QW-1:0]    cur_r, cur_nxt;
  logic signed [QW-1:0]    diff_r, diff_nxt;
  logic signed [QW-1:0]    volts_r, volts_nxt;
  logic signed [PW:0]      acc_r, acc_nxt;
  logic signed [QW-1:0]    pwm_r, pwm_nxt;

  // Shared multiplier.
  logic                    mul_en;
  logic signed [QW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;

  dcmvf_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  logic                    accept;
  logic signed [TSW-1:0]   torque_sum;
  logic signed [PW-FW-1:0] prod_floor;
  logic signed [QW-1:0]    x_sel, xp_sel, yp_sel;
  logic signed [QW-1:0]    y_new;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign torque_in[0] = in_torque_a;
  assign torque_in[1] = in_torque_b;
  assign torque_in[2] = in_torque_c;

  always_comb begin
    torque_sum = '0;
    for (int i = 0; i < TORQUE_INPUTS; i++) begin
      torque_sum = torque_sum + TSW'(torque_r[i]);
    end
  end

  // The scaled product: an arithmetic shift is floor division by 2^16.
  assign prod_floor = mul_p[PW-1:FW];

  // The derivative works on the current first, then on the position.
  assign x_sel  = pos_phase_r ? position_r      : cur_r;
  assign xp_sel = pos_phase_r ? last_position_r : last_current_r;
  assign yp_sel = pos_phase_r ? last_velocity_r : last_rate_r;

  always_comb begin
    logic signed [SW-1:0] filt_acc;
    filt_acc = SW'(acc_r) - SW'(mul_p);
    y_new    = dcmvf_pkg::sat32(SW'(filt_acc >>> FW));
  end

  // Multiplier operand selection.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_MCUR: begin
        mul_a = sum_r;
        mul_b = QW'(regs.inv_torque_constant);
      end
      ST_DM1: begin
        mul_a = diff_r;
        mul_b = QW'(regs.filter_gain);
      end
      ST_DM2: begin
        mul_a = yp_sel;
        mul_b = QW'(regs.filter_pole);
      end
      ST_VE: begin
        mul_a = last_velocity_r;
        mul_b = QW'(regs.back_emf_gain);
      end
      ST_VR: begin
        mul_a = cur_r;
        mul_b = QW'(regs.winding_resistance);
      end
      ST_VL: begin
        mul_a = last_rate_r;
        mul_b = QW'(regs.winding_inductance);
      end
      ST_MPWM: begin
        mul_a = volts_r;
        mul_b = QW'(regs.volt_to_pwm);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Sequencer and datapath.
  always_comb begin
    state_nxt         = state_r;
    pos_phase_nxt     = pos_phase_r;
    out_valid_nxt     = out_valid_r;
    last_current_nxt  = last_current_r;
    last_rate_nxt     = last_rate_r;
    last_position_nxt = last_position_r;
    last_velocity_nxt = last_velocity_r;
    sum_nxt           = sum_r;
    cur_nxt           = cur_r;
    diff_nxt          = diff_r;
    volts_nxt         = volts_r;
    acc_nxt           = acc_r;
    pwm_nxt           = pwm_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = dcmvf_pkg::sat32(SW'(torque_sum));
        state_nxt = ST_MCUR;
      end
      ST_MCUR: state_nxt = ST_CUR;
      ST_CUR: begin
        cur_nxt       = dcmvf_pkg::sat32(SW'(prod_floor));
        pos_phase_nxt = 1'b0;
        state_nxt     = ST_DIFF;
      end
      ST_DIFF: begin
        diff_nxt = dcmvf_pkg::sat32(SW'(x_sel) - SW'(xp_sel));
        if (timing_ok_r) begin
          state_nxt = ST_DM1;
        end else begin
          // Timing invalid: the output holds, only the input history moves.
          if (pos_phase_r) begin
            last_position_nxt = position_r;
            state_nxt         = ST_VE;
          end else begin
            last_current_nxt = cur_r;
            pos_phase_nxt    = 1'b1;
          end
        end
      end
      ST_DM1: state_nxt = ST_DM2;
      ST_DM2: begin
        acc_nxt   = (PW + 1)'(mul_p);
        state_nxt = ST_DY;
      end
      ST_DY: begin
        if (pos_phase_r) begin
          last_position_nxt = position_r;
          last_velocity_nxt = y_new;
          state_nxt         = ST_VE;
        end else begin
          last_current_nxt = cur_r;
          last_rate_nxt    = y_new;
          pos_phase_nxt    = 1'b1;
          state_nxt        = ST_DIFF;
        end
      end
      ST_VE: state_nxt = ST_VR;
      ST_VR: begin
        acc_nxt   = (PW + 1)'(prod_floor);
        state_nxt = ST_VL;
      end
      ST_VL: begin
        acc_nxt   = acc_r + (PW + 1)'(prod_floor);
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        volts_nxt = dcmvf_pkg::sat32(SW'(acc_r) + SW'(prod_floor));
        state_nxt = ST_MPWM;
      end
      ST_MPWM: state_nxt = ST_OUT;
      ST_OUT: begin
        // Wait here until the output register is free.
        if (!out_valid_r || out_ready) begin
          pwm_nxt       = dcmvf_pkg::sat32(SW'(prod_floor));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pos_phase_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      last_current_r  <= '0;
      last_rate_r     <= '0;
      last_position_r <= '0;
      last_velocity_r <= '0;
    end else begin
      state_r         <= state_nxt;
      pos_phase_r     <= pos_phase_nxt;
      out_valid_r     <= out_valid_nxt;
      last_current_r  <= last_current_nxt;
      last_rate_r     <= last_rate_nxt;
      last_position_r <= last_position_nxt;
      last_velocity_r <= last_velocity_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < TORQUE_INPUTS; i++) begin
        torque_r[i] <= torque_in[i];
      end
      position_r  <= in_shaft_pos;
      timing_ok_r <= in_timing_ok;
    end
    sum_r   <= sum_nxt;
    cur_r   <= cur_nxt;
    diff_r  <= diff_nxt;
    volts_r <= volts_nxt;
    acc_r   <= acc_nxt;
    pwm_r   <= pwm_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_command = pwm_r;

endmodule

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for dc_motor_voltage_feedforward_core
// Sends torque and position samples through the input channel while both
// channels idle at random, predicts every drive command with an independent
// fixed-point model of the joint, and compares it with each accepted result.
// ---------------------------------------------------------------------------
module testbench;

  // The bench instantiates the core with all three torque demands in use,
  // and the predictor sums the same number of them.
  localparam int TORQUE_COUNT = 3;

  // Writes to this index must leave every register untouched.
  localparam logic [dcmvf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Random part of the run, and how long the watchdog tolerates a stretch
  // with no item moving on either channel. The slowest legal stretch is a
  // sender gap plus the core's work on one item plus a receiver stall, well below the limit.
  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_GAP      = 18;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // One input item as the core sees it.
  typedef struct packed {
    logic signed [31:0] torque_a;
    logic signed [31:0] torque_b;
    logic signed [31:0] torque_c;
    logic signed [31:0] position;
    logic               timing_ok;
  } sample_t;

  // Clock and reset. Reset is held low from the start and released only once.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // All inputs of the core start at known values.
  logic                             in_valid     = 1'b0;
  logic signed [31:0]               in_torque_a  = '0;
  logic signed [31:0]               in_torque_b  = '0;
  logic signed [31:0]               in_torque_c  = '0;
  logic signed [31:0]               in_shaft_pos = '0;
  logic                             in_timing_ok = 1'b0;
  logic                             out_ready    = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [dcmvf_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [dcmvf_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                             in_ready;
  logic                             out_valid;
  logic signed [31:0]               out_pwm_command;

  dc_motor_voltage_feedforward_core #(
    .TORQUE_INPUTS(TORQUE_COUNT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_torque_a    (in_torque_a),
    .in_torque_b    (in_torque_b),
    .in_torque_c    (in_torque_c),
    .in_shaft_pos   (in_shaft_pos),
    .in_timing_ok   (in_timing_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pwm_command(out_pwm_command),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Register copy and filter history of the predicted joint.
  dcmvf_pkg::cfg_t    joint_regs;
  logic signed [31:0] hist_current;
  logic signed [31:0] hist_current_rate;
  logic signed [31:0] hist_position;
  logic signed [31:0] hist_velocity;

  // Drive commands predicted for accepted items, oldest first.
  logic signed [31:0] pending_pwm[$];
  logic signed [31:0] want_pwm;

  // Idle control: when a side is quiet it never inserts gaps.
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;

  // Running position for the random part, so that most samples form a
  // smooth trajectory and the derivative filters see realistic steps.
  logic signed [31:0] walk_position = '0;

  int mismatches     = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int dropouts       = 0;
  int settings_count = 0;
  int idle_cycles    = 0;

  // -------------------------------------------------------------------------
  // Fixed-point predictor.
  // -------------------------------------------------------------------------

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > Q_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < Q_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Q16.16 product; the arithmetic shift rounds toward minus infinity. All
  // operand pairs used here keep the exact product inside 64 bits.
  function automatic longint q16_product(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  // First-order filtered derivative. With the sample timing invalid the
  // previous output is held; the caller updates the input history either way.
  function automatic logic signed [31:0] filtered_derivative(
    input logic signed [31:0] x,
    input logic signed [31:0] prev_x,
    input logic signed [31:0] prev_y,
    input logic               ok
  );
    longint step;
    longint acc;
    if (!ok) begin
      return prev_y;
    end
    step = clamp_q16(longint'(x) - longint'(prev_x));
    acc  = longint'({1'b0, joint_regs.filter_gain}) * step
         - longint'($signed(joint_regs.filter_pole)) * longint'(prev_y);
    return clamp_q16(acc >>> 16);
  endfunction

  // Works out the drive command of one sample and advances the history.
  function automatic logic signed [31:0] predict_pwm(input sample_t s);
    longint             torque_sum;
    logic signed [31:0] torque;
    logic signed [31:0] current;
    logic signed [31:0] rate;
    logic signed [31:0] velocity;
    logic signed [31:0] volts;
    torque_sum = longint'(s.torque_a);
    if (TORQUE_COUNT > 1) begin
      torque_sum += longint'(s.torque_b);
    end
    if (TORQUE_COUNT > 2) begin
      torque_sum += longint'(s.torque_c);
    end
    torque  = clamp_q16(torque_sum);
    current = clamp_q16(q16_product(torque, longint'({1'b0, joint_regs.inv_torque_constant})));

    rate              = filtered_derivative(current, hist_current, hist_current_rate,
                                            s.timing_ok);
    hist_current      = current;
    hist_current_rate = rate;
    velocity          = filtered_derivative(s.position, hist_position, hist_velocity,
                                            s.timing_ok);
    hist_position     = s.position;
    hist_velocity     = velocity;

    // The resistive term always uses the present current, even when the
    // derivative outputs are being held.
    volts = clamp_q16(q16_product(longint'({1'b0, joint_regs.back_emf_gain}), velocity)
                    + q16_product(longint'({1'b0, joint_regs.winding_resistance}), current)
                    + q16_product(longint'({1'b0, joint_regs.winding_inductance}), rate));
    return clamp_q16(q16_product(volts, longint'({1'b0, joint_regs.volt_to_pwm})));
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------

  function automatic sample_t make_sample(
    input logic signed [31:0] a,
    input logic signed [31:0] b,
    input logic signed [31:0] c,
    input logic signed [31:0] pos,
    input logic               ok
  );
    sample_t s;
    s.torque_a  = a;
    s.torque_b  = b;
    s.torque_c  = c;
    s.position  = pos;
    s.timing_ok = ok;
    return s;
  endfunction

  function automatic dcmvf_pkg::cfg_t make_regs(
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] inv,
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] bemf,
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] res,
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] ind,
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] vpwm,
    input logic [dcmvf_pkg::CFG_DATA_W-1:0] gain,
    input logic [dcmvf_pkg::POLE_W-1:0]     pole
  );
    dcmvf_pkg::cfg_t r;
    r.inv_torque_constant = inv;
    r.back_emf_gain       = bemf;
    r.winding_resistance  = res;
    r.winding_inductance  = ind;
    r.volt_to_pwm         = vpwm;
    r.filter_gain         = gain;
    r.filter_pole         = pole;
    return r;
  endfunction

  // Sends one item. The gap is drawn first; valid is only lowered when a gap
  // follows, so back-to-back items keep valid high without a glitch. The
  // prediction is taken at the edge where the item is accepted.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_torque_a  <= s.torque_a;
    in_torque_b  <= s.torque_b;
    in_torque_c  <= s.torque_c;
    in_shaft_pos <= s.position;
    in_timing_ok <= s.timing_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pwm.push_back(predict_pwm(s));
    items_sent++;
    if (!s.timing_ok) begin
      dropouts++;
    end
  endtask

  // Holds the sender back until every predicted command has come out, then
  // lets the core settle before returning.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dcmvf_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [dcmvf_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes a full register set while the core is idle. The pole write carries
  // random upper bits, which the core must ignore, and every set ends with a
  // write to the unused index.
  task automatic load_registers(input dcmvf_pkg::cfg_t r);
    write_reg(dcmvf_pkg::REG_INV_TORQUE_CONSTANT, r.inv_torque_constant);
    write_reg(dcmvf_pkg::REG_BACK_EMF_GAIN, r.back_emf_gain);
    write_reg(dcmvf_pkg::REG_WINDING_RESISTANCE, r.winding_resistance);
    write_reg(dcmvf_pkg::REG_WINDING_INDUCTANCE, r.winding_inductance);
    write_reg(dcmvf_pkg::REG_VOLT_TO_PWM, r.volt_to_pwm);
    write_reg(dcmvf_pkg::REG_FILTER_GAIN, r.filter_gain);
    write_reg(dcmvf_pkg::REG_FILTER_POLE, {14'($urandom), r.filter_pole});
    write_reg(REG_UNUSED, 31'($urandom));
    cfg_we     <= 1'b0;
    joint_regs  = r;
    settings_count++;
  endtask

  // Gain draws: zero, full scale, unity, a realistic range up to 8.0, or any
  // pattern at all.
  function automatic logic [dcmvf_pkg::CFG_DATA_W-1:0] random_gain();
    unique case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 31'd65536;
      3:       return 31'($urandom);
      default: return 31'($urandom_range(0, 524288));
    endcase
  endfunction

  // Pole draws: mostly the physical range -1.0..0, sometimes a positive or
  // arbitrary pattern.
  function automatic logic [dcmvf_pkg::POLE_W-1:0] random_pole();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 17'h1_0000;
      2:       return 17'($urandom);
      3:       return 17'($urandom_range(1, 65535));
      default: return 17'(-int'($urandom_range(0, 65536)));
    endcase
  endfunction

  // The first two random phases are forced to the two corners of the
  // register space; the rest are drawn.
  function automatic dcmvf_pkg::cfg_t random_settings(input int phase);
    if (phase == 0) begin
      return make_regs('0, '0, '0, '0, '0, '0, '0);
    end
    if (phase == 1) begin
      return make_regs('1, '1, '1, '1, '1, '1, 17'h1_0000);
    end
    return make_regs(random_gain(), random_gain(), random_gain(), random_gain(),
                     random_gain(), random_gain(), random_pole());
  endfunction

  function automatic logic signed [31:0] random_torque();
    unique case ($urandom_range(0, 9))
      0:       return 32'($urandom);
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return '0;
      default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  // Most samples continue the smooth trajectory; a few jump anywhere, which
  // can drive the position difference into saturation.
  function automatic sample_t random_sample();
    if ($urandom_range(0, 24) == 0) begin
      walk_position = 32'($urandom);
    end else begin
      walk_position = walk_position + 32'(int'($urandom_range(0, 16384)) - 8192);
    end
    return make_sample(random_torque(), random_torque(), random_torque(), walk_position,
                       $urandom_range(0, 9) != 0);
  endfunction

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Reset values: unity gains on torque and PWM, everything else zero, so
  // the drive command must stay at zero whatever the torques.
  task automatic test_reset_values();
    send_sample(make_sample(32'sd65536, 32'sd0, 32'sd0, 32'sd1000, 1'b1));
    send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 1'b1));
    send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 1'b0));
  endtask

  // Field extremes: torque sums that saturate both ways, the largest
  // position steps, and a register set with every gain at full scale.
  task automatic test_field_extremes();
    wait_all_results();
    load_registers(make_regs('1, 31'd65536, 31'd65536, 31'd65536, 31'd65536,
                             31'd65536, 17'h1_0000));
    send_sample(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 1'b1));
    send_sample(make_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 1'b1));
    send_sample(make_sample(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000,
                            32'sh8000_0000, 1'b1));
    send_sample(make_sample(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh0000_0000,
                            32'sh0000_0000, 1'b0));
    send_sample(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
                            32'sh0000_0000, 1'b1));
    send_sample(make_sample(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
                            32'shFFFF_FFFF, 1'b1));

    wait_all_results();
    load_registers(make_regs('1, '1, '1, '1, '1, '1, '0));
    send_sample(make_sample(32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0000,
                            32'sh7FFF_FFFF, 1'b1));
    send_sample(make_sample(32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000,
                            32'sh8000_0000, 1'b1));
    send_sample(make_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                            32'sh0001_0000, 1'b0));
    send_sample(make_sample(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
                            32'sh0000_0000, 1'b1));
  endtask

  // Filter behavior with realistic motor constants: a position ramp, timing
  // dropouts that hold both derivatives while the history still advances,
  // then a positive pole pattern that must be taken as a positive value.
  task automatic test_filter_cases();
    wait_all_results();
    load_registers(make_regs(31'd131072, 31'd32768, 31'd98304, 31'd655, 31'd6553600,
                             31'd5957818, 17'(-59578)));
    send_sample(make_sample(32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1'b1));
    send_sample(make_sample(32'sd131072, 32'sd0, 32'sd0, 32'sd131072, 1'b1));
    send_sample(make_sample(32'sd131072, -32'sd65536, 32'sd32768, 32'sd196608, 1'b0));
    send_sample(make_sample(-32'sd65536, 32'sd0, 32'sd0, 32'sd262144, 1'b0));
    send_sample(make_sample(-32'sd65536, 32'sd0, 32'sd0, 32'sd327680, 1'b1));
    send_sample(make_sample(32'sd0, 32'sd0, 32'sd0, 32'sd327680, 1'b1));

    wait_all_results();
    load_registers(make_regs(31'd65536, 31'd65536, 31'd65536, 31'd65536, 31'd65536,
                             31'd65536, 17'h0_FFFF));
    send_sample(make_sample(32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1'b1));
    send_sample(make_sample(32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1'b1));
    send_sample(make_sample(32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 1'b1));
  endtask

  // Random traffic in phases. Each phase loads a fresh register set and
  // picks whether either side runs without gaps; now and then the sender
  // pauses until the core has delivered every outstanding result.
  task automatic test_random_traffic();
    int          phase;
    int          sent;
    int unsigned count;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_all_results();
      load_registers(random_settings(phase));
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      count          = $urandom_range(40, 160);
      // The last phase stops at the planned item count.
      if (count > unsigned'(RANDOM_ITEMS - sent)) begin
        count = unsigned'(RANDOM_ITEMS - sent);
      end
      repeat (count) begin
        send_sample(random_sample());
        sent++;
        if ($urandom_range(0, 60) == 0) begin
          wait_all_results();
        end
      end
      phase++;
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Sequence of the run.
  // -------------------------------------------------------------------------

  initial begin
    joint_regs        = make_regs(dcmvf_pkg::INV_TORQUE_CONSTANT_RST, '0, '0, '0,
                                  dcmvf_pkg::VOLT_TO_PWM_RST, '0, '0);
    hist_current      = '0;
    hist_current_rate = '0;
    hist_position     = '0;
    hist_velocity     = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_field_extremes();
    test_filter_cases();
    test_random_traffic();

    // Drain, then give the core time to show any stray result.
    wait_all_results();
    repeat (40) @(posedge clk);

    $display("Checked %0d drive commands from %0d samples (%0d with timing invalid).",
             results_seen, items_sent, dropouts);
    $display("Register sets loaded: %0d, including both corners and a positive pole.",
             settings_count);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: before each result a stall is drawn, so ready drops at
  // every point of the core's work, including while a result is waiting.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic report_mismatch(
    input string              what,
    input logic signed [31:0] expected,
    input logic signed [31:0] actual
  );
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected %0d (0x%08h), got %0d (0x%08h)",
               what, expected, expected, actual, actual);
    end
  endtask

  // Every accepted result is compared with the oldest prediction. Values are
  // sampled at the clock edge, before any of the edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_pwm.size() == 0) begin
        report_mismatch("result with nothing pending", 32'sd0, out_pwm_command);
      end else begin
        want_pwm = pending_pwm.pop_front();
        if (out_pwm_command !== want_pwm) begin
          report_mismatch("pwm_command", want_pwm, out_pwm_command);
        end
      end
    end
  end

  // Watchdog: a long stretch with no item moving on either channel means the
  // core has hung or lost a result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
                 STALL_LIMIT, pending_pwm.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

FILE: dc_motor_voltage_feedforward_core.f
hw/rtl/dcmvf_pkg.sv
hw/rtl/dcmvf_cfg.sv
hw/rtl/dcmvf_mul.sv
hw/rtl/dc_motor_voltage_feedforward_core.sv
test/testbench.sv
